### rtl/spwq_pkg.sv
// ----------------------------------------------------------------------------
// spwq_pkg: shared types and codes for the stable priority wait queue
// Transaction payloads, command and status codes, and the per-cell control
// bundle that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spwq_pkg;

   localparam int KEY_BITS  = 64;
   localparam int ID_FIELD  = 8;

   // command codes of the request transaction
   typedef enum logic [1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_WAKE    = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   // status codes of the result transaction
   localparam logic [1:0] ST_WOKEN    = 2'd0;
   localparam logic [1:0] ST_RELEASED = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   typedef struct packed {
      logic [1:0]          func;
      logic [ID_FIELD-1:0] waiter_id;
      logic [KEY_BITS-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [ID_FIELD-1:0] waiter_out;
      logic [KEY_BITS-1:0] priority_out;
      logic                last;
   } rsp_type;

   // one stored waiter
   typedef struct packed {
      logic [ID_FIELD-1:0] id;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   // control broadcast to all cells
   typedef struct packed {
      logic      insert;
      logic      shift;
      entry_type new_ent;
   } cell_ctrl_type;

endpackage

### rtl/spwq_cell.sv
// ----------------------------------------------------------------------------
// spwq_cell: one slot of the sorted wait queue
// Holds a waiter and a valid flag. On insert it keeps its entry, takes the
// new waiter, or takes its upstream neighbor's entry; on drain it takes its
// downstream neighbor's entry so the queue moves toward the head.
// ----------------------------------------------------------------------------
module spwq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  spwq_pkg::cell_ctrl_type ctrl,
   input  logic                    up_valid,
   input  logic                    up_keep,
   input  spwq_pkg::entry_type     up_ent,
   input  logic                    down_valid,
   input  spwq_pkg::entry_type     down_ent,
   output logic                    valid,
   output logic                    keep,
   output spwq_pkg::entry_type     ent
);
   import spwq_pkg::*;

   logic      valid_ff, valid_in;
   entry_type ent_ff, ent_in;

   // entry stays in place when its key is not above the new key (stable order)
   assign keep = valid_ff && (ent_ff.key <= ctrl.new_ent.key);

   // next slot contents
   always_comb begin
      valid_in = valid_ff;
      ent_in   = ent_ff;
      if (ctrl.insert) begin
         if (keep) begin
            valid_in = valid_ff;
            ent_in   = ent_ff;
         end else if (up_keep) begin
            valid_in = 1'b1;
            ent_in   = ctrl.new_ent;
         end else begin
            valid_in = up_valid;
            ent_in   = up_ent;
         end
      end else if (ctrl.shift) begin
         valid_in = down_valid;
         ent_in   = down_ent;
      end
   end

   // valid flag is control state; payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign valid = valid_ff;
   assign ent   = ent_ff;

endmodule

### rtl/stable_priority_wait_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_wait_queue: stable sorted priority wait queue, top level
// Inserts can be issued every cycle while not busy; a full queue rejects
// with one result in the next cycle. Wake or release drains one waiter
// per cycle from the head via the drain flag and the result register,
// with busy high while the drain runs. Drain rate is set by the single
// result port; insert rate by the parallel compare in every cell.
// Synchronous reset empties the queue; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module stable_priority_wait_queue #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spwq_pkg::req_type req,
   output logic              rsp_strobe,
   output spwq_pkg::rsp_type rsp
);
   import spwq_pkg::*;

   localparam int STORE_BITS = (ID_BITS < ID_FIELD) ? ID_BITS : ID_FIELD;
   localparam logic [ID_FIELD-1:0] ID_MASK = ID_FIELD'((1 << STORE_BITS) - 1);

   logic          cell_valid [DEPTH];
   logic          cell_keep  [DEPTH];
   entry_type     cell_ent   [DEPTH];
   cell_ctrl_type ctrl;

   logic          drain_ff, drain_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic accept, is_insert, is_drain, full, do_reject, do_wake;
   entry_type new_ent;

   // decode of the accepted transaction
   assign accept    = start && !drain_ff;
   assign is_insert = (req.func == FUNC_INSERT);
   assign is_drain  = (req.func == FUNC_WAKE) || (req.func == FUNC_RELEASE);
   assign full      = cell_valid[DEPTH-1];
   assign do_reject = accept && is_insert && full;
   assign do_wake   = accept && is_drain && cell_valid[0];
   assign new_ent.id  = req.waiter_id & ID_MASK;
   assign new_ent.key = req.priority_req;

   assign ctrl.insert  = accept && is_insert && !full;
   assign ctrl.shift   = drain_ff;
   assign ctrl.new_ent = new_ent;

   // chain of cells, head at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      up_valid, up_keep, down_valid;
      entry_type up_ent, down_ent;
      if (i == 0) begin : g_head
         assign up_valid = 1'b0;
         assign up_keep  = 1'b1;
         assign up_ent   = new_ent;
      end else begin : g_mid
         assign up_valid = cell_valid[i-1];
         assign up_keep  = cell_keep[i-1];
         assign up_ent   = cell_ent[i-1];
      end
      if (i == DEPTH-1) begin : g_tail
         assign down_valid = 1'b0;
         assign down_ent   = cell_ent[i];
      end else begin : g_body
         assign down_valid = cell_valid[i+1];
         assign down_ent   = cell_ent[i+1];
      end
      spwq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .up_valid   (up_valid),
         .up_keep    (up_keep),
         .up_ent     (up_ent),
         .down_valid (down_valid),
         .down_ent   (down_ent),
         .valid      (cell_valid[i]),
         .keep       (cell_keep[i]),
         .ent        (cell_ent[i])
      );
   end

   // drain sequencing and result register
   always_comb begin
      drain_in      = drain_ff;
      status_in     = status_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      priority if (do_reject) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.status       = ST_REJECTED;
         rsp_in.waiter_out   = new_ent.id;
         rsp_in.priority_out = new_ent.key;
         rsp_in.last         = 1'b1;
      end else if (do_wake) begin
         drain_in  = 1'b1;
         status_in = (req.func == FUNC_WAKE) ? ST_WOKEN : ST_RELEASED;
      end else if (drain_ff) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.status       = status_ff;
         rsp_in.waiter_out   = cell_ent[0].id;
         rsp_in.priority_out = cell_ent[0].key;
         rsp_in.last         = !cell_valid[1];
         drain_in            = cell_valid[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         drain_ff      <= drain_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = drain_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

### test/spwq_checker.sv
// ----------------------------------------------------------------------------
// spwq_checker: result checker for the stable priority wait queue
// Watches the command and result channels, keeps its own sorted copy of the
// waiters, works out the results that each accepted command owes, and
// compares every strobed result, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module spwq_checker #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  spwq_pkg::req_type req,
   input  logic              rsp_strobe,
   input  spwq_pkg::rsp_type rsp,
   output int                fail_count,
   output int                outstanding
);
   import spwq_pkg::*;

   // identities keep only ID_BITS bits
   localparam logic [ID_FIELD-1:0] ID_KEEP =
      (ID_BITS >= ID_FIELD) ? '1 : ID_FIELD'((1 << ID_BITS) - 1);

   // sorted copy of the waiters, head at index 0
   logic [ID_FIELD-1:0] held_id  [DEPTH];
   logic [KEY_BITS-1:0] held_key [DEPTH];
   int                  held_count = 0;

   // results the queue still owes, oldest first
   rsp_type notices_due [$];
   rsp_type due;
   int      errs = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // apply one accepted command to the copy and queue the results it causes
   task automatic queue_apply(input req_type cmd);
      int                  pos;
      logic [ID_FIELD-1:0] id;
      rsp_type             note;
      id = cmd.waiter_id & ID_KEEP;
      case (func_type'(cmd.func))
         FUNC_INSERT: begin
            if (held_count >= DEPTH) begin
               // full: waiter dropped, request echoed back
               note.status       = ST_REJECTED;
               note.waiter_out   = id;
               note.priority_out = cmd.priority_req;
               note.last         = 1'b1;
               notices_due.push_back(note);
            end else begin
               // stable placement: after the last key <= new key
               pos = 0;
               for (int i = 0; i < held_count; i++)
                  if (held_key[i] <= cmd.priority_req) pos = i + 1;
               for (int i = held_count; i > pos; i--) begin
                  held_id[i]  = held_id[i-1];
                  held_key[i] = held_key[i-1];
               end
               held_id[pos]  = id;
               held_key[pos] = cmd.priority_req;
               held_count++;
            end
         end
         FUNC_WAKE, FUNC_RELEASE: begin
            // drain from the head; nothing owed when empty
            for (int k = 0; k < held_count; k++) begin
               note.status       = (cmd.func == FUNC_WAKE) ? ST_WOKEN : ST_RELEASED;
               note.waiter_out   = held_id[k];
               note.priority_out = held_key[k];
               note.last         = (k == held_count - 1);
               notices_due.push_back(note);
            end
            held_count = 0;
         end
         default: ;
      endcase
   endtask

   task automatic match_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         errs++;
      end
   endtask

   // results first (they belong to earlier commands), then the new command
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         notices_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (notices_due.size() == 0) begin
               $error("result with none owed: status %0h waiter %0h key %0h last %0b",
                      rsp.status, rsp.waiter_out, rsp.priority_out, rsp.last);
               errs++;
            end else begin
               due = notices_due.pop_front();
               match_field("status", 64'(due.status), 64'(rsp.status));
               match_field("waiter_out", 64'(due.waiter_out), 64'(rsp.waiter_out));
               match_field("priority_out", due.priority_out, rsp.priority_out);
               match_field("last", 64'(due.last), 64'(rsp.last));
            end
         end
         if (start && !busy) queue_apply(req);
      end
      fail_count  <= errs;
      outstanding <= notices_due.size();
   end

endmodule

### test/tb_stable_priority_wait_queue.sv
// ----------------------------------------------------------------------------
// tb_stable_priority_wait_queue: testbench top for the stable priority queue
// Drives a directed set of commands (key and identity extremes, equal keys,
// overflow, empty drains, the unused code), then random fill-and-drain runs
// with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_stable_priority_wait_queue;
   import spwq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int ID_BITS      = 8;
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = DEPTH + 8;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      fail_count;
   int      outstanding;
   int      cycle_count = 0;
   int      fed;
   int      run_len;
   int      key_mode;
   bit      rush;
   func_type fn;

   always #6 clock = ~clock;

   stable_priority_wait_queue #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

   spwq_checker #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp_item),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one transaction: optional idle gap, then hold start until accepted
   task automatic issue(input func_type f, input logic [7:0] id,
                        input logic [63:0] key, input bit no_gap);
      int      gap;
      req_type cmd;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      cmd.func         = f;
      cmd.waiter_id    = id;
      cmd.priority_req = key;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= cmd;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // key styles: full random, tiny range for ties, extremes, clustered
   function automatic logic [63:0] pick_key(input int mode);
      case (mode)
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 3));
         2: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return '1;
               2:       return 64'd1;
               default: return {1'b1, 63'd0};
            endcase
         end
         default: return {32'($urandom_range(0, 2)), 30'd0, 2'($urandom_range(0, 3))};
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // drains of an empty queue and the unused code owe nothing
      issue(FUNC_RELEASE, 8'h00, '0, 1'b0);
      issue(FUNC_WAKE, 8'hFF, '1, 1'b0);
      issue(FUNC_UNUSED, 8'hFF, '1, 1'b0);

      // extremes and ties: equal keys must keep arrival order
      issue(FUNC_INSERT, 8'hFF, '1, 1'b0);
      issue(FUNC_INSERT, 8'h00, '0, 1'b0);
      issue(FUNC_INSERT, 8'hA5, 64'd5, 1'b0);
      issue(FUNC_INSERT, 8'h5A, 64'd5, 1'b1);
      issue(FUNC_INSERT, 8'h3C, '0, 1'b1);
      issue(FUNC_WAKE, 8'h00, '0, 1'b0);

      // fill with falling keys, so each lands at the head, then overflow
      for (int i = 0; i < DEPTH; i++)
         issue(FUNC_INSERT, 8'(i), 64'(DEPTH - i), i[0]);
      issue(FUNC_INSERT, 8'hFF, '1, 1'b1);
      issue(FUNC_INSERT, 8'h00, '0, 1'b0);
      issue(FUNC_RELEASE, 8'hFF, '1, 1'b1);

      // random fill-and-drain runs with some noise
      fed = 0;
      while (fed < RANDOM_ITEMS) begin
         rush = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            run_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 4)
                                                   : $urandom_range(0, 10);
            key_mode = $urandom_range(0, 3);
            for (int i = 0; i < run_len; i++)
               issue(FUNC_INSERT, 8'($urandom), pick_key(key_mode), rush);
            fn = ($urandom_range(0, 1) == 0) ? FUNC_WAKE : FUNC_RELEASE;
            issue(fn, 8'($urandom), {$urandom, $urandom}, rush);
            fed += run_len + 1;
         end else begin
            fn = func_type'($urandom_range(0, 3));
            issue(fn, 8'($urandom), {$urandom, $urandom}, rush);
            if (fn != FUNC_UNUSED) fed++;
         end
      end
      start <= 1'b0;

      // let every owed result arrive, then watch for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
